### src/rms_over_window_macros.svh
// assertion macros shared by the rms_over_window rtl
`ifndef RMS_OVER_WINDOW_MACROS_SVH
`define RMS_OVER_WINDOW_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define RMSW_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rmsw assertion failed");
// expression must never be true out of reset
`define RMSW_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("rmsw forbidden condition seen");
`else
`define RMSW_ASSERT(lbl, clk, rstn, prop)
`define RMSW_NEVER(lbl, clk, rstn, expr)
`endif

`endif

### src/rmsw_pkg.sv
// shared widths, constants and types of the rms window block
`default_nettype none

package rmsw_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int RMS_W           = 16;
  localparam int CFG_W           = 7;
  localparam int SQ_W            = 2 * SAMPLE_W;
  localparam int MAX_SAMPLES_DEF = 64;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd40;

  // status of the queue between front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

### src/rmsw_front.sv
// front end: sample acceptance, squaring, window accumulation and close detection
`default_nettype none
`include "rms_over_window_macros.svh"

module rmsw_front #(
  parameter int MAX_SAMPLES = rmsw_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [rmsw_pkg::CFG_W-1:0]         cfg_sample_count,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [rmsw_pkg::SAMPLE_W-1:0]      in_sample_value,
  input  wire rmsw_pkg::q_stat_t                  q_stat,
  output logic                                    q_push,
  output logic [rmsw_pkg::SQ_W+$clog2(MAX_SAMPLES)+$clog2(MAX_SAMPLES+1)-1:0] q_data
);
  import rmsw_pkg::*;

  localparam int SUM_W = SQ_W + $clog2(MAX_SAMPLES);
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0] cfg_r;
  logic             sq_vld_r;
  logic             sq_vld_nxt;
  logic [SQ_W-1:0]  sq_r;
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_inc;
  logic [CMP_W-1:0] n_eff;
  logic [CMP_W-1:0] cfg_ext;
  logic             close;
  logic             accept;
  logic             adv;

  // effective window length: zero acts as one, clamp at the maximum
  always_comb begin
    cfg_ext = CMP_W'(cfg_r);
    if (cfg_r == '0) begin
      n_eff = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(MAX_SAMPLES)) begin
      n_eff = CMP_W'(MAX_SAMPLES);
    end else begin
      n_eff = cfg_ext;
    end
  end

  assign sum_nxt    = sum_r + SUM_W'(sq_r);
  assign cnt_inc    = cnt_r + CNT_W'(1);
  assign close      = CMP_W'(cnt_inc) >= n_eff;
  assign in_stall   = sq_vld_r && close && q_stat.full;
  assign accept     = in_valid && !in_stall;
  assign adv        = sq_vld_r && !in_stall;
  assign sq_vld_nxt = accept || (sq_vld_r && in_stall);
  assign q_push     = adv && close;
  assign q_data     = {sum_nxt, cnt_inc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r    <= CFG_RESET;
      sq_vld_r <= 1'b0;
      sum_r    <= '0;
      cnt_r    <= '0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_sample_count;
      end
      sq_vld_r <= sq_vld_nxt;
      if (adv) begin
        sum_r <= close ? '0 : sum_nxt;
        cnt_r <= close ? '0 : cnt_inc;
      end
    end
  end

  // square registered straight off the input port
  always_ff @(posedge clk) begin
    if (accept) begin
      sq_r <= in_sample_value * in_sample_value;
    end
  end

  `RMSW_ASSERT(a_cnt_in_range, clk, rst_n, CMP_W'(cnt_r) < CMP_W'(MAX_SAMPLES))
  `RMSW_ASSERT(a_close_clears, clk, rst_n, q_push |=> (cnt_r == '0 && sum_r == '0))

endmodule

`default_nettype wire

### src/rmsw_fifo.sv
// two-entry queue of closed windows between front and back
`default_nettype none
`include "rms_over_window_macros.svh"

module rmsw_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output rmsw_pkg::q_stat_t     stat
);
  import rmsw_pkg::*;

  logic [WIDTH-1:0] ent_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;
  logic [1:0]       cnt_nxt;

  assign stat.full  = cnt_r == 2'd2;
  assign stat.empty = cnt_r == 2'd0;
  assign pop_data   = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  `RMSW_NEVER(a_no_push_full, clk, rst_n, push && stat.full)
  `RMSW_NEVER(a_no_pop_empty, clk, rst_n, pop && stat.empty)

endmodule

`default_nettype wire

### src/rmsw_back.sv
// back end: iterative divide by sample count, bit-pair square root, output register
`default_nettype none
`include "rms_over_window_macros.svh"

module rmsw_back #(
  parameter int MAX_SAMPLES = rmsw_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire rmsw_pkg::q_stat_t            q_stat,
  input  wire logic [rmsw_pkg::SQ_W+$clog2(MAX_SAMPLES)+$clog2(MAX_SAMPLES+1)-1:0] q_data,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [rmsw_pkg::RMS_W-1:0]        out_rms_value
);
  import rmsw_pkg::*;

  localparam int SUM_W  = SQ_W + $clog2(MAX_SAMPLES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int STEP_W = $clog2(SUM_W);
  localparam int REM_W  = RMS_W + 1;
  localparam int TRY_W  = RMS_W + 3;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_SQRT = 4'b0100,
    ST_PUSH = 4'b1000
  } state_t;

  state_t            state_r;
  state_t            state_nxt;
  logic [STEP_W-1:0] step_r;
  logic [SUM_W-1:0]  q_r;
  logic [SUM_W-1:0]  q_nxt;
  logic [CNT_W-1:0]  div_r;
  logic [CNT_W-1:0]  drem_r;
  logic [CNT_W-1:0]  drem_nxt;
  logic [CNT_W:0]    d_try;
  logic [CNT_W:0]    d_sub;
  logic              d_ge;
  logic [SQ_W-1:0]   v_r;
  logic [REM_W-1:0]  srem_r;
  logic [REM_W-1:0]  srem_nxt;
  logic [RMS_W-1:0]  root_r;
  logic [RMS_W-1:0]  root_nxt;
  logic [TRY_W-1:0]  s_try;
  logic [TRY_W-1:0]  s_trial;
  logic [TRY_W-1:0]  s_sub;
  logic              s_ge;
  logic              out_vld_r;
  logic [RMS_W-1:0]  out_r;
  logic              out_load;

  // one quotient bit per cycle, msb first
  always_comb begin
    d_try    = {drem_r, q_r[SUM_W-1]};
    d_sub    = d_try - {1'b0, div_r};
    d_ge     = d_try >= {1'b0, div_r};
    drem_nxt = d_ge ? d_sub[CNT_W-1:0] : d_try[CNT_W-1:0];
    q_nxt    = {q_r[SUM_W-2:0], d_ge};
  end

  // one root bit per cycle from the next bit pair of the mean
  always_comb begin
    s_try    = {srem_r, v_r[SQ_W-1 -: 2]};
    s_trial  = {1'b0, root_r, 2'b01};
    s_sub    = s_try - s_trial;
    s_ge     = s_try >= s_trial;
    srem_nxt = s_ge ? s_sub[REM_W-1:0] : s_try[REM_W-1:0];
    root_nxt = {root_r[RMS_W-2:0], s_ge};
  end

  assign out_load = (state_r == ST_PUSH) && (!out_vld_r || !out_stall);
  assign q_pop    = (state_r == ST_IDLE) && !q_stat.empty;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_r == '0) begin
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (step_r == '0) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        {q_r, div_r} <= q_data;
        drem_r       <= '0;
        step_r       <= STEP_W'(SUM_W - 1);
      end
      ST_DIV: begin
        q_r    <= q_nxt;
        drem_r <= drem_nxt;
        if (step_r == '0) begin
          // mean of squares never exceeds one full-scale square
          v_r    <= q_nxt[SQ_W-1:0];
          srem_r <= '0;
          root_r <= '0;
          step_r <= STEP_W'(RMS_W - 1);
        end else begin
          step_r <= step_r - STEP_W'(1);
        end
      end
      ST_SQRT: begin
        v_r    <= {v_r[SQ_W-3:0], 2'b00};
        srem_r <= srem_nxt;
        root_r <= root_nxt;
        step_r <= step_r - STEP_W'(1);
      end
      default: begin
        step_r <= step_r;
      end
    endcase
    if (out_load) begin
      out_r <= root_r;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_rms_value = out_r;

  `RMSW_ASSERT(a_div_nonzero, clk, rst_n, (state_r == ST_DIV) |-> (div_r != '0))
  `RMSW_ASSERT(a_pop_starts_div, clk, rst_n, q_pop |=> (state_r == ST_DIV))

endmodule

`default_nettype wire

### src/rms_over_window.sv
// top level of the windowed integer rms block
`default_nettype none

// flow: a closing sample is squared into a register and then pushed into the window queue,
//   then its window runs through the divider, the square root and the output register
// throughput: one sample per cycle at the input unless a closing window finds the queue full;
//   the bit-serial divider and square root unit finish one window before taking the next
// reset: synchronous active-low rst_n clears sum, count, queue and output valid,
//   and loads a window length of 40 samples

module rms_over_window #(
  parameter int MAX_SAMPLES = rmsw_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [rmsw_pkg::CFG_W-1:0]    cfg_sample_count,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [rmsw_pkg::SAMPLE_W-1:0] in_sample_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [rmsw_pkg::RMS_W-1:0]         out_rms_value
);
  import rmsw_pkg::*;

  // one queue entry carries the window sum and the samples actually taken
  localparam int SUM_W = SQ_W + $clog2(MAX_SAMPLES);
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int ENT_W = SUM_W + CNT_W;

  q_stat_t          q_stat;
  logic             q_push;
  logic             q_pop;
  logic [ENT_W-1:0] q_wdata;
  logic [ENT_W-1:0] q_rdata;

  // front: takes a transfer every cycle unless a closing window finds the queue full
  rmsw_front #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_sample_count (cfg_sample_count),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_value  (in_sample_value),
    .q_stat           (q_stat),
    .q_push           (q_push),
    .q_data           (q_wdata)
  );

  // queue decouples the accumulator from the slow divide and root
  rmsw_fifo #(
    .WIDTH (ENT_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .stat      (q_stat)
  );

  // back: truncating divide, floor root, result held in the output register
  rmsw_back #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .q_data        (q_rdata),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_rms_value (out_rms_value)
  );

endmodule

`default_nettype wire
